@@ rtl/core/slps_pkg.sv @@
// Package for the status LED pattern sequencer: codes, colour type and pattern tables.
// No dependencies; used by the sequencer module.
package slps_pkg;

   // Item commands
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_MODE  = 2'd1,
      CMD_FLASH = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Display modes (codes above MODE_CONNECTED show as boot)
   localparam logic [2:0] MODE_BOOT       = 3'd0;
   localparam logic [2:0] MODE_AP         = 3'd1;
   localparam logic [2:0] MODE_AP_FALLBK  = 3'd2;
   localparam logic [2:0] MODE_CONNECTING = 3'd3;
   localparam logic [2:0] MODE_CONNECTED  = 3'd4;

   // Flash kinds
   localparam logic [1:0] KIND_KEY = 2'd0;
   localparam logic [1:0] KIND_OK  = 2'd1;
   localparam logic [1:0] KIND_ERR = 2'd2;
   localparam logic [1:0] KIND_BAD = 2'd3;

   // Configuration register indexes
   localparam logic CSR_BRIGHT_LOW  = 1'b0;
   localparam logic CSR_BRIGHT_HIGH = 1'b1;

   localparam logic [7:0] BRIGHT_LOW_RST  = 8'd8;
   localparam logic [7:0] BRIGHT_HIGH_RST = 8'd40;

   localparam int QUEUE_DEPTH_DEF = 4;

   // Phase counter and blink timing
   localparam logic [5:0] PHASE_LAST   = 6'd59;
   localparam logic [5:0] AP_PERIOD    = 6'd20;
   localparam logic [5:0] AP_ON_END    = 6'd4;
   localparam logic [5:0] FB_RED_START = 6'd7;
   localparam logic [5:0] FB_RED_END   = 6'd9;
   localparam logic [5:0] CONN_PERIOD  = 6'd6;
   localparam logic [5:0] CONN_ON_END  = 6'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Pattern tables: on ticks minus one, off ticks minus one, repeats
   function automatic logic [1:0] lit_span_m1(input logic [1:0] kind);
      case (kind)
         KIND_KEY: lit_span_m1 = 2'd1;
         KIND_OK:  lit_span_m1 = 2'd2;
         KIND_ERR: lit_span_m1 = 2'd2;
         default:  lit_span_m1 = 2'd1;
      endcase
   endfunction

   function automatic logic [1:0] dark_span_m1(input logic [1:0] kind);
      case (kind)
         KIND_KEY: dark_span_m1 = 2'd0;
         KIND_OK:  dark_span_m1 = 2'd1;
         KIND_ERR: dark_span_m1 = 2'd1;
         default:  dark_span_m1 = 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] repeat_count(input logic [1:0] kind);
      case (kind)
         KIND_KEY: repeat_count = 2'd1;
         KIND_OK:  repeat_count = 2'd2;
         KIND_ERR: repeat_count = 2'd3;
         default:  repeat_count = 2'd1;
      endcase
   endfunction

   function automatic rgb_type flash_rgb(input logic [1:0] kind, input logic [7:0] hi);
      rgb_type c;
      c = '0;
      case (kind)
         KIND_KEY: begin
            c.green = hi;
            c.blue  = hi;
         end
         KIND_OK:  c.green = hi;
         KIND_ERR: c.red = hi;
         default:  c = '0;
      endcase
      return c;
   endfunction

   // Mode colour at a phase below 60; the remainders use compare/subtract and
   // a reciprocal multiply, h/3 likewise
   function automatic rgb_type mode_rgb(input logic [2:0] mode, input logic [5:0] phase,
                                        input logic [7:0] hi, input logic [7:0] lo);
      logic [5:0]  p20;
      logic [11:0] prod6;
      logic [3:0]  q6;
      logic [5:0]  p6;
      logic [16:0] prod3;
      rgb_type     c;
      p20 = (phase >= 6'd40) ? phase - 6'd40 :
            (phase >= AP_PERIOD) ? phase - AP_PERIOD : phase;
      prod6 = {6'd0, phase} * 12'd43;
      q6 = prod6[11:8];
      p6 = phase - ({2'd0, q6} * CONN_PERIOD);
      prod3 = {9'd0, hi} * 17'd171;
      c = '0;
      case (mode)
         MODE_AP: begin
            if (p20 < AP_ON_END) c.blue = hi;
         end
         MODE_AP_FALLBK: begin
            if (p20 < AP_ON_END) c.blue = hi;
            else if (p20 >= FB_RED_START && p20 < FB_RED_END) c.red = hi;
         end
         MODE_CONNECTING: begin
            if (p6 < CONN_ON_END) begin
               c.red   = hi;
               c.green = prod3[16:9];
            end
         end
         MODE_CONNECTED: c.green = lo;
         default: begin
            c.red   = lo;
            c.green = lo;
            c.blue  = lo;
         end
      endcase
      return c;
   endfunction

endpackage

@@ rtl/core/slps_req_if.sv @@
// Request channel of the status LED pattern sequencer: valid/ready and one event item.
// Depends on nothing but the signal widths of the event fields.
interface slps_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [2:0] mode_value;
   logic [1:0] flash_kind;

   modport source (output valid, output command, output mode_value, output flash_kind,
                   input ready);
   modport sink (input valid, input command, input mode_value, input flash_kind,
                 output ready);
endinterface

@@ rtl/core/slps_rsp_if.sv @@
// Response channel of the status LED pattern sequencer: valid/ready and one colour item.
// Depends on nothing but the signal widths of the result fields.
interface slps_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       flash_dropped;
   logic       flash_playing;

   modport source (output valid, output red, output green, output blue,
                   output flash_dropped, output flash_playing, input ready);
   modport sink (input valid, input red, input green, input blue,
                 input flash_dropped, input flash_playing, output ready);
endinterface

@@ rtl/core/status_led_pattern_sequencer.sv @@
// A result item is valid in the cycle after its event item is accepted.
// Throughput: one event item per cycle while results are taken; the result register stands between the channels,
// so a new item is taken in the same cycle as the waiting result is taken.
// Reset (synchronous, active high): boot mode, phase 0, queue empty, no flash, colour
// dark, brightness 8/40, no result pending. Queue contents are not cleared.
// Depends on slps_pkg, slps_req_if and slps_rsp_if.
module status_led_pattern_sequencer
   import slps_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   slps_req_if.sink   req_bus,
   slps_rsp_if.source rsp_bus,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [7:0]  bright_low_ff, bright_high_ff;
   logic [2:0]  mode_ff, mode_in;
   logic [5:0]  phase_ff, phase_in, phase_next;
   logic [1:0]  queue_ff [QUEUE_DEPTH];
   logic [1:0]  queue_in [QUEUE_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic        active_ff, active_in;
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  rep_ff, rep_in, rep_dec;
   logic        off_ff, off_in;
   logic [1:0]  ptl_ff, ptl_in;
   rgb_type     shown_ff, shown_in;
   logic        dropped_ff, dropped_in;
   logic        rsp_valid_ff;

   logic        req_accept;
   logic        do_pop, do_push, do_start;
   logic [1:0]  start_kind, start_kind_ok;

   // Handshake: accept whenever the result register is free or being emptied
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign phase_next = (phase_ff == PHASE_LAST) ? 6'd0 : phase_ff + 6'd1;
   assign rep_dec    = (rep_ff != 2'd0) ? rep_ff - 2'd1 : rep_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bright_low_ff  <= BRIGHT_LOW_RST;
         bright_high_ff <= BRIGHT_HIGH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BRIGHT_LOW:  bright_low_ff  <= csr_wdata;
            CSR_BRIGHT_HIGH: bright_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Event decode: tick pattern stepping, mode write, flash request
   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      active_in  = active_ff;
      kind_in    = kind_ff;
      rep_in     = rep_ff;
      off_in     = off_ff;
      ptl_in     = ptl_ff;
      shown_in   = shown_ff;
      dropped_in = 1'b0;
      do_pop     = 1'b0;
      do_push    = 1'b0;
      do_start   = 1'b0;
      start_kind = req_bus.flash_kind;

      case (cmd_type'(req_bus.command))
         CMD_TICK: begin
            if (!active_ff) begin
               if (count_ff != '0) begin
                  do_pop = 1'b1;
               end else begin
                  shown_in = mode_rgb(mode_ff, phase_ff, bright_high_ff, bright_low_ff);
                  phase_in = phase_next;
               end
            end else if (ptl_ff != 2'd0) begin
               ptl_in   = ptl_ff - 2'd1;
               shown_in = off_ff ? '0 : flash_rgb(kind_ff, bright_high_ff);
            end else if (!off_ff) begin
               off_in   = 1'b1;
               ptl_in   = dark_span_m1(kind_ff);
               shown_in = '0;
            end else if (rep_dec != 2'd0) begin
               rep_in   = rep_dec;
               off_in   = 1'b0;
               ptl_in   = lit_span_m1(kind_ff);
               shown_in = flash_rgb(kind_ff, bright_high_ff);
            end else begin
               // flash over: phase steps once, then next queued flash or mode colour
               rep_in    = rep_dec;
               active_in = 1'b0;
               off_in    = 1'b0;
               phase_in  = phase_next;
               if (count_ff != '0) begin
                  do_pop = 1'b1;
               end else begin
                  shown_in = mode_rgb(mode_ff, phase_ff, bright_high_ff, bright_low_ff);
               end
            end
         end
         CMD_MODE: mode_in = req_bus.mode_value;
         CMD_FLASH: begin
            if (req_bus.flash_kind == KIND_BAD) begin
               dropped_in = 1'b1;
            end else if (!active_ff && count_ff == '0) begin
               do_start = 1'b1;
            end else if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
               do_push = 1'b1;
            end else begin
               dropped_in = 1'b1;
            end
         end
         default: ;
      endcase

      if (do_pop) begin
         do_start   = 1'b1;
         start_kind = queue_ff[0];
      end

      // Start of a flash: first on tick is this item
      start_kind_ok = (start_kind == KIND_BAD) ? KIND_KEY : start_kind;
      if (do_start) begin
         active_in = 1'b1;
         kind_in   = start_kind_ok;
         rep_in    = repeat_count(start_kind_ok);
         off_in    = 1'b0;
         ptl_in    = lit_span_m1(start_kind_ok);
         shown_in  = flash_rgb(start_kind_ok, bright_high_ff);
      end
   end

   // Queue update: shift out at the head, write at the fill count
   always_comb begin
      queue_in = queue_ff;
      count_in = count_ff;
      if (do_pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            queue_in[i] = queue_ff[i + 1];
         end
         count_in = count_ff - CNT_W'(1);
      end else if (do_push) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (count_ff == CNT_W'(i)) queue_in[i] = req_bus.flash_kind;
         end
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Queue entries: no reset, read only once written
   always_ff @(posedge clock) begin
      if (req_accept) queue_ff <= queue_in;
   end

   // Sequencer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BOOT;
         phase_ff     <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         kind_ff      <= KIND_KEY;
         rep_ff       <= '0;
         off_ff       <= 1'b0;
         ptl_ff       <= '0;
         shown_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            mode_ff    <= mode_in;
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            active_ff  <= active_in;
            kind_ff    <= kind_in;
            rep_ff     <= rep_in;
            off_ff     <= off_in;
            ptl_ff     <= ptl_in;
            shown_ff   <= shown_in;
            dropped_ff <= dropped_in;
         end
         if (req_accept) rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.red           = shown_ff.red;
   assign rsp_bus.green         = shown_ff.green;
   assign rsp_bus.blue          = shown_ff.blue;
   assign rsp_bus.flash_dropped = dropped_ff;
   assign rsp_bus.flash_playing = active_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("flash queue count above depth");

   a_queue_needs_flash: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> active_ff)
      else $error("flashes queued while none plays");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_LAST)
      else $error("phase counter out of range");

   a_off_needs_flash: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> !off_ff)
      else $error("dark part flagged with no flash playing");

   a_drop_from_flash: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (!dropped_ff || $past(req_bus.command) == CMD_FLASH))
      else $error("drop flag raised for an item that is no flash request");

endmodule
